// File: hdl/brnl_pkg.sv
// brnl_pkg: widths, request and register codes, shared types of the bitmap rank lookup
// no dependencies; compiled first
`timescale 1ns / 1ps

package brnl_pkg;

  // sizing
  localparam int unsigned PREFIX_ENTRIES     = 200;
  localparam int unsigned IMAGE_ADDR_BITS    = 22;
  localparam int unsigned COUNT_TABLE_OFFSET = 1250;

  localparam int unsigned IMG_AW      = IMAGE_ADDR_BITS;
  localparam int unsigned IMG_DEPTH   = 32'd1 << IMAGE_ADDR_BITS;
  localparam int unsigned BANK_DEPTH  = IMG_DEPTH / 2;
  localparam int unsigned TBL_IDX_W   = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;

  // field widths
  localparam int unsigned REQ_TYPE_W  = 2;
  localparam int unsigned BYTE_ADDR_W = 22;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned OFS_W       = 22;
  localparam int unsigned PREFIX_W    = 10;
  localparam int unsigned SUB_W       = 14;
  localparam int unsigned ID_W        = 16;

  // configuration
  localparam int unsigned IMG_SIZE_W  = 23;
  localparam int unsigned COMBO_W     = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 23;

  // address sums: offset plus count table offset plus doubled rank stay below this
  localparam int unsigned SUM_W       = 24;
  localparam int unsigned BIDX_W      = SUB_W - 3;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_WR_BYTE  = 2'd0,
    REQ_WR_TABLE = 2'd1,
    REQ_QUERY    = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE  = 2'd0,
    CFG_COMBO_COUNT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [OFS_W-1:0] bitmap_base;
    logic [OFS_W-1:0] record_base;
  } tbl_entry_t;

  typedef struct packed {
    logic              en;
    logic [IMG_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } img_wr_t;

endpackage

// File: hdl/brnl_intf.sv
// brnl_req_if, brnl_rsp_if, brnl_cfg_if: valid/ready channels of the bitmap rank lookup
// depends on brnl_pkg
`timescale 1ns / 1ps

interface brnl_req_if import brnl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [REQ_TYPE_W-1:0]  req_type;
  logic [BYTE_ADDR_W-1:0] byte_address;
  logic [BYTE_W-1:0]      byte_value;
  logic [SLOT_W-1:0]      table_slot;
  logic [OFS_W-1:0]       bitmap_base;
  logic [OFS_W-1:0]       record_base;
  logic [PREFIX_W-1:0]    prefix_number;
  logic [SUB_W-1:0]       sub_number;

  modport source (
    output valid, req_type, byte_address, byte_value, table_slot,
           bitmap_base, record_base, prefix_number, sub_number,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_address, byte_value, table_slot,
           bitmap_base, record_base, prefix_number, sub_number,
    output ready
  );
endinterface

interface brnl_rsp_if import brnl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [ID_W-1:0] record_id;

  modport source (output valid, found, record_id, input ready);
  modport sink (input valid, found, record_id, output ready);
endinterface

interface brnl_cfg_if import brnl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/brnl_ram.sv
// brnl_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module brnl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/brnl_prefix_tbl.sv
// brnl_prefix_tbl: prefix table ram with per-entry valid bits, absent entries read as zero
// depends on brnl_pkg and brnl_ram
`timescale 1ns / 1ps

module brnl_prefix_tbl import brnl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [TBL_IDX_W-1:0] waddr_i,
  input  tbl_entry_t           wdata_i,
  input  logic                 re_i,
  input  logic [TBL_IDX_W-1:0] raddr_i,
  output tbl_entry_t           rdata_o
);

  logic [PREFIX_ENTRIES-1:0] vld_q;
  logic                      vld_rd_q;
  tbl_entry_t                ram_rdata;

  brnl_ram #(
    .WIDTH ($bits(tbl_entry_t)),
    .DEPTH (PREFIX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        vld_rd_q <= vld_q[raddr_i];
      end
    end
  end

  // never-written entry holds zero offsets
  assign rdata_o = vld_rd_q ? ram_rdata : '0;

endmodule

// File: hdl/brnl_pair_rd.sv
// brnl_pair_rd: image copy split in even and odd byte banks for unaligned 16-bit reads
// depends on brnl_pkg and brnl_ram
`timescale 1ns / 1ps

module brnl_pair_rd import brnl_pkg::*; (
  input  logic              clk_i,
  input  img_wr_t           wr_i,
  input  logic              re_i,
  input  logic [IMG_AW-1:0] raddr_i,
  output logic [15:0]       rdata_o
);

  logic [IMG_AW-2:0] half;
  logic [IMG_AW-2:0] even_ra;
  logic [BYTE_W-1:0] even_rd;
  logic [BYTE_W-1:0] odd_rd;
  logic              par_q;

  assign half    = raddr_i[IMG_AW-1:1];
  // odd start: low byte in odd bank, high byte in the next even word
  assign even_ra = raddr_i[0] ? half + (IMG_AW-1)'(1) : half;

  brnl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_even (
    .clk_i   (clk_i),
    .we_i    (wr_i.en && !wr_i.addr[0]),
    .waddr_i (wr_i.addr[IMG_AW-1:1]),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (even_ra),
    .rdata_o (even_rd)
  );

  brnl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd (
    .clk_i   (clk_i),
    .we_i    (wr_i.en && wr_i.addr[0]),
    .waddr_i (wr_i.addr[IMG_AW-1:1]),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (half),
    .rdata_o (odd_rd)
  );

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      par_q <= raddr_i[0];
    end
  end

  // little-endian: low byte at the start address
  assign rdata_o = par_q ? {even_rd, odd_rd} : {odd_rd, even_rd};

endmodule

// File: hdl/bitmap_rank_number_lookup.sv
// bitmap_rank_number_lookup: top level, five-stage lookup pipeline and configuration registers
// depends on brnl_pkg, brnl_intf, brnl_ram, brnl_prefix_tbl, brnl_pair_rd
`timescale 1ns / 1ps

// Takes one request transfer per clock unless a stalled result holds the pipeline, and
// gives one result transfer per query, in request order, from the output register. Write
// requests load image bytes or prefix table entries and give no result. A query reads its
// prefix table entry at the request edge, then makes three dependent image reads in later
// stages: the bitmap byte, the 16-bit running count, the 16-bit record id. Each read has its
// own copy of the image, and each image byte write goes into all three copies in the stage
// where that copy is read, so every query sees exactly the writes that came before it;
// storage is three times 2^IMAGE_ADDR_BITS bytes. The prefix table is empty after reset,
// with no clearing pass; image bytes are undefined until written. Configuration (image_size,
// combo_count) may be written only while no query is in flight.

module bitmap_rank_number_lookup import brnl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  brnl_req_if.sink    req_i,
  brnl_rsp_if.source  rsp_o,
  brnl_cfg_if.sink    cfg_i
);

  // popcount of the bitmap bits below the tested one
  function automatic logic [3:0] low_pop(input logic [7:0] bits, input logic [2:0] pos);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(pos)) begin
        cnt = cnt + 4'(bits[i]);
      end
    end
    return cnt;
  endfunction

  // configuration registers
  logic [IMG_SIZE_W-1:0] image_size_q;
  logic [COMBO_W-1:0]    combo_q;
  logic [SUM_W-1:0]      size_ext;

  assign cfg_i.ready = 1'b1;
  assign size_ext    = SUM_W'(image_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= '0;
      combo_q      <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_IMAGE_SIZE:  image_size_q <= cfg_i.data[IMG_SIZE_W-1:0];
        CFG_COMBO_COUNT: combo_q      <= cfg_i.data[COMBO_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic adv1, adv2, adv3, adv4, adv5, rdy_out;

  // stage payloads
  req_type_e              typ1_q, typ2_q, typ3_q, typ4_q, typ5_q;
  logic [BYTE_ADDR_W-1:0] baddr1_q, baddr2_q, baddr3_q, baddr4_q;
  logic [BYTE_W-1:0]      bval1_q, bval2_q, bval3_q, bval4_q;
  logic                   pok1_q;
  logic [SUB_W-1:0]       sub1_q;
  logic                   hit2_q, hit3_q, hit4_q, hit5_q;
  logic                   hit2_d, hit3_d, hit5_d;
  logic [SUM_W-1:0]       cnt2_q, cnt2_d;
  logic [OFS_W-1:0]       rec2_q, rec3_q;
  logic [2:0]             bit2_q;
  logic [3:0]             pop3_q, pop3_d;
  logic [SUM_W-1:0]       pos4_q, pos4_d;
  logic                   found_q, found_d;
  logic [ID_W-1:0]        id_q, id_d;

  assign rdy_out     = !ov_q || rsp_o.ready;
  // non-query items retire at the last stage without a result
  assign adv5        = v5_q && ((typ5_q != REQ_QUERY) || rdy_out);
  assign adv4        = v4_q && (!v5_q || adv5);
  assign adv3        = v3_q && (!v4_q || adv4);
  assign adv2        = v2_q && (!v3_q || adv3);
  assign adv1        = v1_q && (!v2_q || adv2);
  assign req_i.ready = !v1_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        v1_q <= req_i.valid;
      end
      if (!v2_q || adv2) begin
        v2_q <= adv1;
      end
      if (!v3_q || adv3) begin
        v3_q <= adv2;
      end
      if (!v4_q || adv4) begin
        v4_q <= adv3;
      end
      if (!v5_q || adv5) begin
        v5_q <= adv4;
      end
      if (rdy_out) begin
        ov_q <= adv5 && (typ5_q == REQ_QUERY);
      end
    end
  end

  // stage 0: request transfer, prefix table write or read
  logic       in_acc;
  req_type_e  in_typ;
  logic       pok_in;
  logic       slot_ok;
  tbl_entry_t tbl_wdata;
  tbl_entry_t tbl_rdata;

  assign in_acc    = req_i.valid && req_i.ready;
  assign in_typ    = req_type_e'(req_i.req_type);
  assign pok_in    = 32'(req_i.prefix_number) < PREFIX_ENTRIES;
  assign slot_ok   = 32'(req_i.table_slot) < PREFIX_ENTRIES;
  assign tbl_wdata = '{bitmap_base: req_i.bitmap_base, record_base: req_i.record_base};

  brnl_prefix_tbl u_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_acc && (in_typ == REQ_WR_TABLE) && slot_ok),
    .waddr_i (TBL_IDX_W'(req_i.table_slot)),
    .wdata_i (tbl_wdata),
    .re_i    (in_acc && (in_typ == REQ_QUERY)),
    .raddr_i (pok_in ? TBL_IDX_W'(req_i.prefix_number) : '0),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      typ1_q   <= in_typ;
      baddr1_q <= req_i.byte_address;
      bval1_q  <= req_i.byte_value;
      pok1_q   <= pok_in;
      sub1_q   <= req_i.sub_number;
    end
  end

  // stage 1: entry checks, bitmap byte address, bitmap copy read or write
  logic [BIDX_W-1:0] bidx1;
  logic [SUM_W-1:0]  bm_addr;
  logic [BYTE_W-1:0] bm_rdata;

  assign bidx1   = sub1_q[SUB_W-1:3];
  assign bm_addr = SUM_W'(tbl_rdata.bitmap_base) + SUM_W'(bidx1);
  assign cnt2_d  = SUM_W'(tbl_rdata.bitmap_base) + SUM_W'(COUNT_TABLE_OFFSET)
                 + SUM_W'({bidx1, 1'b0});
  assign hit2_d  = (typ1_q == REQ_QUERY) && pok1_q
                && (tbl_rdata.bitmap_base != '0) && (tbl_rdata.record_base != '0)
                && (bm_addr < size_ext) && (32'(bm_addr) < IMG_DEPTH);

  brnl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (IMG_DEPTH)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (adv1 && (typ1_q == REQ_WR_BYTE)),
    .waddr_i (IMG_AW'(baddr1_q)),
    .wdata_i (bval1_q),
    .re_i    (adv1 && (typ1_q == REQ_QUERY)),
    .raddr_i (IMG_AW'(bm_addr)),
    .rdata_o (bm_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      typ2_q   <= typ1_q;
      baddr2_q <= baddr1_q;
      bval2_q  <= bval1_q;
      hit2_q   <= hit2_d;
      cnt2_q   <= cnt2_d;
      rec2_q   <= tbl_rdata.record_base;
      bit2_q   <= sub1_q[2:0];
    end
  end

  // stage 2: bit test, local rank, running count read
  logic [SUM_W-1:0] cnt_hi;
  logic [15:0]      cnt_rdata;
  img_wr_t          cnt_wr;

  assign cnt_hi = cnt2_q + SUM_W'(1);
  assign hit3_d = hit2_q && bm_rdata[bit2_q]
               && (cnt_hi < size_ext) && (32'(cnt_hi) < IMG_DEPTH);
  assign pop3_d = low_pop(bm_rdata, bit2_q);
  assign cnt_wr = '{en: adv2 && (typ2_q == REQ_WR_BYTE), addr: IMG_AW'(baddr2_q),
                    data: bval2_q};

  brnl_pair_rd u_count (
    .clk_i   (clk_i),
    .wr_i    (cnt_wr),
    .re_i    (adv2 && (typ2_q == REQ_QUERY)),
    .raddr_i (IMG_AW'(cnt2_q)),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      typ3_q   <= typ2_q;
      baddr3_q <= baddr2_q;
      bval3_q  <= bval2_q;
      hit3_q   <= hit3_d;
      rec3_q   <= rec2_q;
      pop3_q   <= pop3_d;
    end
  end

  // stage 3: rank kept at 17 bits, then doubled into the record address
  logic [16:0] rank3;

  assign rank3  = 17'(cnt_rdata) + 17'(pop3_q);
  assign pos4_d = SUM_W'(rec3_q) + SUM_W'({rank3, 1'b0});

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      typ4_q   <= typ3_q;
      baddr4_q <= baddr3_q;
      bval4_q  <= bval3_q;
      hit4_q   <= hit3_q;
      pos4_q   <= pos4_d;
    end
  end

  // stage 4: record bounds check and record id read
  logic [SUM_W-1:0] pos_hi;
  logic [15:0]      rec_rdata;
  img_wr_t          rec_wr;

  assign pos_hi = pos4_q + SUM_W'(1);
  assign hit5_d = hit4_q && (pos_hi < size_ext) && (32'(pos_hi) < IMG_DEPTH);
  assign rec_wr = '{en: adv4 && (typ4_q == REQ_WR_BYTE), addr: IMG_AW'(baddr4_q),
                    data: bval4_q};

  brnl_pair_rd u_record (
    .clk_i   (clk_i),
    .wr_i    (rec_wr),
    .re_i    (adv4 && (typ4_q == REQ_QUERY)),
    .raddr_i (IMG_AW'(pos4_q)),
    .rdata_o (rec_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      typ5_q <= typ4_q;
      hit5_q <= hit5_d;
    end
  end

  // stage 5: id range check into the output register
  assign found_d = hit5_q && (rec_rdata < combo_q);
  assign id_d    = found_d ? rec_rdata : '0;

  always_ff @(posedge clk_i) begin
    if (adv5 && rdy_out) begin
      found_q <= found_d;
      id_q    <= id_d;
    end
  end

  assign rsp_o.valid     = ov_q;
  assign rsp_o.found     = found_q;
  assign rsp_o.record_id = id_q;

  // a reported id is always below the configured record count
  a_id_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.found |-> (rsp_o.record_id < combo_q))
    else $error("found result with id out of range");

  // only queries can carry a hit down the pipe
  a_hit_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && hit2_q |-> (typ2_q == REQ_QUERY))
    else $error("hit flag on a write request");

  // a stalled query in the last stage is still there next cycle
  a_st5_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !adv5 |=> v5_q)
    else $error("stalled query dropped from last stage");

  // input back-pressure only when the first stage is occupied
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> v1_q && v2_q)
    else $error("request side stalled with free stages");

endmodule
